// ===== hw/rtl/sfdt_pkg.sv =====
package sfdt_pkg;

	localparam int SLOTS_DEF = 192;
	localparam int NAME_BYTES_DEF = 32;
	localparam logic [31:0] FIRST_OFFSET = 32'd32768;
	localparam logic [31:0] OFFSET_GAP = 32'd512;

	typedef enum logic [1:0] {
		FN_OPEN_NUM  = 2'd0,
		FN_OPEN_NAME = 2'd1,
		FN_CREATE    = 2'd2,
		FN_DELETE    = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_READY     = 2'd0,
		ST_NO_FILE   = 2'd1,
		ST_NAME_EXISTS = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_LAST,
		S_COMMIT,
		S_OUT
	} state_t;

endpackage

// ===== hw/rtl/save_file_directory_table_core.sv =====
// Request path: the slot memory is read one slot at a time during the scan, each read
// is registered, a decide step writes the result registers, then out_valid is raised.
// A new request is taken only after the scan over the slot memory has finished,
// and it waits until the result has been taken.
// Reset: after arst_n releases, a clearing pass writes every slot to zero,
// during which no request is taken.
module save_file_directory_table_core #(
	parameter int SLOTS = sfdt_pkg::SLOTS_DEF,
	parameter int NAME_BYTES = sfdt_pkg::NAME_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  func,
	input  logic [7:0]  file_number,
	input  logic [63:0] name_part0,
	input  logic [63:0] name_part1,
	input  logic [63:0] name_part2,
	input  logic [63:0] name_part3,
	input  logic [5:0]  name_length,
	input  logic [23:0] file_size,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [7:0]  slot_index,
	output logic [7:0]  found_number,
	output logic [23:0] found_length,
	output logic [31:0] raw_offset
);
	localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int NB = NAME_BYTES * 8;
	localparam int LW = $clog2(NAME_BYTES + 1);

	typedef struct packed {
		logic [7:0]    num;
		logic [NB-1:0] name;
		logic [23:0]   len;
		logic [31:0]   off;
	} entry_t;

	entry_t mem [SLOTS];
	entry_t rd_s1;
	entry_t wr_data;
	logic [AW-1:0] wr_addr;
	logic wr_en;

	sfdt_pkg::state_t state_q, state_n;
	logic [AW-1:0] addr_q;
	logic [AW-1:0] raddr_s1;
	logic rvalid_s1;

	logic [1:0]    func_q;
	logic [7:0]    fnum_q;
	logic [NB-1:0] qname_q;
	logic [NB-1:0] mask_q;
	logic [23:0]   size_q;

	logic          hit_q;
	logic [AW-1:0] hit_idx_q;
	entry_t        hit_e_q;
	logic          free_q;
	logic [AW-1:0] free_idx_q;
	logic [8:0]    cnum_q;
	logic [31:0]   coff_q;

	logic [1:0]  st_q;
	logic [7:0]  idx_q, fn_q;
	logic [23:0] fl_q;
	logic [31:0] ro_q;

	logic [255:0] qall;
	logic [LW-1:0] qlen;
	logic [NB-1:0] qmask;
	logic name_hit, num_hit, occ;

	assign qall = {name_part3, name_part2, name_part1, name_part0};
	assign qlen = (name_length > 6'(NAME_BYTES)) ? LW'(NAME_BYTES) : LW'(name_length);
	always_comb begin
		for (int k = 0; k < NAME_BYTES; k++) begin
			qmask[k*8 +: 8] = (k < int'(qlen)) ? 8'hFF : 8'h00;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_s1 <= mem[addr_q];
	end

	assign occ = rd_s1.num != 8'd0;
	assign name_hit = (rd_s1.name[7:0] != 8'd0) &&
		(((rd_s1.name ^ qname_q) & mask_q) == '0);
	assign num_hit = (fnum_q != 8'd0) && (rd_s1.num == fnum_q);

	always_comb begin
		state_n = state_q;
		wr_en = 1'b0;
		wr_addr = addr_q;
		wr_data = '0;
		in_ready = 1'b0;
		unique case (state_q)
			sfdt_pkg::S_CLEAR: begin
				wr_en = 1'b1;
				if (addr_q == AW'(SLOTS - 1)) state_n = sfdt_pkg::S_IDLE;
			end
			sfdt_pkg::S_IDLE: begin
				in_ready = !out_valid;
				if (in_valid && !out_valid) state_n = sfdt_pkg::S_SCAN;
			end
			sfdt_pkg::S_SCAN: begin
				if (addr_q == AW'(SLOTS - 1)) state_n = sfdt_pkg::S_LAST;
			end
			sfdt_pkg::S_LAST: state_n = sfdt_pkg::S_COMMIT;
			sfdt_pkg::S_COMMIT: begin
				state_n = sfdt_pkg::S_OUT;
				if (func_q == sfdt_pkg::FN_DELETE && hit_q) begin
					wr_en = 1'b1;
					wr_addr = hit_idx_q;
				end else if (func_q == sfdt_pkg::FN_CREATE && !hit_q && free_q &&
						cnum_q <= 9'd255) begin
					wr_en = 1'b1;
					wr_addr = free_idx_q;
					wr_data.num = cnum_q[7:0];
					wr_data.name = qname_q & mask_q;
					wr_data.len = size_q;
					wr_data.off = coff_q;
				end
			end
			sfdt_pkg::S_OUT: state_n = sfdt_pkg::S_IDLE;
			default: state_n = sfdt_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sfdt_pkg::S_CLEAR;
			addr_q <= '0;
			rvalid_s1 <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_n;
			rvalid_s1 <= (state_q == sfdt_pkg::S_SCAN);
			if (state_q == sfdt_pkg::S_CLEAR || state_q == sfdt_pkg::S_SCAN) begin
				addr_q <= (addr_q == AW'(SLOTS - 1)) ? '0 : addr_q + AW'(1);
			end
			if (state_q == sfdt_pkg::S_OUT) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		raddr_s1 <= addr_q;
		if (state_q == sfdt_pkg::S_IDLE && in_valid && !out_valid) begin
			func_q <= func;
			fnum_q <= file_number;
			qname_q <= qall[NB-1:0];
			mask_q <= qmask;
			size_q <= file_size;
			hit_q <= 1'b0;
			free_q <= 1'b0;
			cnum_q <= 9'd1;
			coff_q <= sfdt_pkg::FIRST_OFFSET;
		end
		if (rvalid_s1) begin
			if (!hit_q && ((func_q == sfdt_pkg::FN_OPEN_NUM) ? num_hit : name_hit)) begin
				hit_q <= 1'b1;
				hit_idx_q <= raddr_s1;
				hit_e_q <= rd_s1;
			end
			if (!free_q && !occ) begin
				free_q <= 1'b1;
				free_idx_q <= raddr_s1;
			end
			if (occ && {1'b0, rd_s1.num} <= cnum_q) cnum_q <= {1'b0, rd_s1.num} + 9'd1;
			if (occ && rd_s1.off <= coff_q + {8'd0, size_q})
				coff_q <= rd_s1.off + {8'd0, rd_s1.len} + sfdt_pkg::OFFSET_GAP;
		end
		if (state_q == sfdt_pkg::S_COMMIT) begin
			priority if (func_q == sfdt_pkg::FN_CREATE && !hit_q && free_q &&
					cnum_q <= 9'd255) begin
				st_q <= sfdt_pkg::ST_READY;
				idx_q <= 8'(free_idx_q);
				fn_q <= cnum_q[7:0];
				fl_q <= size_q;
				ro_q <= coff_q;
			end else if (func_q != sfdt_pkg::FN_CREATE && hit_q) begin
				st_q <= sfdt_pkg::ST_READY;
				idx_q <= 8'(hit_idx_q);
				fn_q <= hit_e_q.num;
				fl_q <= hit_e_q.len;
				ro_q <= hit_e_q.off;
			end else begin
				{idx_q, fn_q, fl_q, ro_q} <= '0;
				if (func_q != sfdt_pkg::FN_CREATE) st_q <= sfdt_pkg::ST_NO_FILE;
				else if (hit_q) st_q <= sfdt_pkg::ST_NAME_EXISTS;
				else st_q <= sfdt_pkg::ST_FULL;
			end
		end
	end

	assign status = st_q;
	assign slot_index = idx_q;
	assign found_number = fn_q;
	assign found_length = fl_q;
	assign raw_offset = ro_q;
endmodule

// ===== hw/rtl/sfdt_checker.sv =====
module sfdt_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [1:0] status,
	input logic [7:0] slot_index
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(slot_index))
		else $error("result changed while stalled");
	a_one_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second request taken during scan");
	a_no_take_pending: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("request taken while result pending");
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != sfdt_pkg::ST_READY |-> slot_index == 8'd0)
		else $error("failure result carries slot");
endmodule

bind save_file_directory_table_core sfdt_checker u_sfdt_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .status(status),
	.slot_index(slot_index)
);

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

	localparam int NSLOT = 192;
	localparam int STALL_LIMIT = 20000;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic [1:0] func = 0;
	logic [7:0] file_number = 0;
	logic [63:0] name_part0 = 0, name_part1 = 0, name_part2 = 0, name_part3 = 0;
	logic [5:0] name_length = 0;
	logic [23:0] file_size = 0;
	logic out_valid;
	logic out_ready = 0;
	logic [1:0] status;
	logic [7:0] slot_index;
	logic [7:0] found_number;
	logic [23:0] found_length;
	logic [31:0] raw_offset;

	save_file_directory_table_core dut (.*);

	always #4 clk = ~clk;

	typedef struct packed {
		sfdt_pkg::status_t st;
		logic [7:0] idx;
		logic [7:0] num;
		logic [23:0] len;
		logic [31:0] off;
	} dir_result_t;

	logic [7:0] dir_num [NSLOT];
	logic [7:0] dir_name [NSLOT][32];
	logic [23:0] dir_len [NSLOT];
	logic [31:0] dir_off [NSLOT];

	dir_result_t pending_results[$];
	int errors = 0;
	int requests = 0;
	int responses = 0;
	int idle_pct = 17;
	int stall_cycles = 0;
	int n_create_ok = 0;
	int n_full = 0;
	bit done = 0;

	function automatic logic [7:0] qbyte(logic [255:0] q, int k);
		return q[8*k +: 8];
	endfunction

	function automatic int find_name(logic [255:0] q, logic [5:0] nl);
		int l;
		bit same;
		l = (nl > 32) ? 32 : nl;
		for (int s = 0; s < NSLOT; s++) begin
			if (dir_name[s][0] == 0)
				continue;
			same = 1;
			for (int k = 0; k < l; k++)
				if (dir_name[s][k] != qbyte(q, k))
					same = 0;
			if (same)
				return s;
		end
		return -1;
	endfunction

	function automatic dir_result_t slot_result(int s);
		dir_result_t r;
		r.st = sfdt_pkg::ST_READY;
		r.idx = s[7:0];
		r.num = dir_num[s];
		r.len = dir_len[s];
		r.off = dir_off[s];
		return r;
	endfunction

	function automatic dir_result_t fail_result(sfdt_pkg::status_t st);
		dir_result_t r;
		r = '0;
		r.st = st;
		return r;
	endfunction

	function automatic void wipe_slot(int s);
		dir_num[s] = 0;
		dir_len[s] = 0;
		dir_off[s] = 0;
		for (int k = 0; k < 32; k++)
			dir_name[s][k] = 0;
	endfunction

	function automatic dir_result_t apply_request(sfdt_pkg::func_t f, logic [7:0] fnum,
			logic [255:0] q, logic [5:0] nl, logic [23:0] sz);
		int s;
		int fs;
		int l;
		int unsigned num;
		logic [31:0] off;
		s = -1;
		case (f)
			sfdt_pkg::FN_OPEN_NUM: begin
				if (fnum != 0)
					for (int i = 0; i < NSLOT; i++)
						if (s < 0 && dir_num[i] == fnum)
							s = i;
				return (s >= 0) ? slot_result(s) : fail_result(sfdt_pkg::ST_NO_FILE);
			end
			sfdt_pkg::FN_OPEN_NAME: begin
				s = find_name(q, nl);
				return (s >= 0) ? slot_result(s) : fail_result(sfdt_pkg::ST_NO_FILE);
			end
			sfdt_pkg::FN_CREATE: begin
				if (find_name(q, nl) >= 0)
					return fail_result(sfdt_pkg::ST_NAME_EXISTS);
				fs = -1;
				num = 1;
				off = sfdt_pkg::FIRST_OFFSET;
				for (int i = 0; i < NSLOT; i++)
					if (fs < 0 && dir_num[i] == 0)
						fs = i;
				for (int i = 0; i < NSLOT; i++)
					if (dir_num[i] != 0 && dir_num[i] <= num)
						num = dir_num[i] + 1;
				for (int i = 0; i < NSLOT; i++)
					if (dir_num[i] != 0 && dir_off[i] <= off + 32'(sz))
						off = dir_off[i] + 32'(dir_len[i]) + sfdt_pkg::OFFSET_GAP;
				if (fs < 0 || num > 255) begin
					n_full++;
					return fail_result(sfdt_pkg::ST_FULL);
				end
				wipe_slot(fs);
				l = (nl > 32) ? 32 : nl;
				for (int k = 0; k < l; k++)
					dir_name[fs][k] = qbyte(q, k);
				dir_num[fs] = num[7:0];
				dir_len[fs] = sz;
				dir_off[fs] = off;
				n_create_ok++;
				return slot_result(fs);
			end
			default: begin
				dir_result_t r;
				s = find_name(q, nl);
				if (s < 0)
					return fail_result(sfdt_pkg::ST_NO_FILE);
				r = slot_result(s);
				wipe_slot(s);
				return r;
			end
		endcase
	endfunction

	task automatic send_request(sfdt_pkg::func_t f, logic [7:0] fnum, logic [255:0] q,
			logic [5:0] nl, logic [23:0] sz);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 0;
			@(negedge clk);
		end
		func <= f;
		file_number <= fnum;
		{name_part3, name_part2, name_part1, name_part0} <= q;
		name_length <= nl;
		file_size <= sz;
		in_valid <= 1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pending_results.push_back(apply_request(f, fnum, q, nl, sz));
		requests++;
		@(negedge clk);
	endtask

	// short names drawn from a small alphabet so prefixes collide often
	function automatic logic [255:0] short_name(int nbytes);
		logic [255:0] q;
		q = '0;
		for (int k = 0; k < nbytes; k++)
			q[8*k +: 8] = 8'($urandom_range(1, 3));
		return q;
	endfunction

	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= idle_pct);

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			dir_result_t e;
			responses++;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result status %0d", $time, status);
				errors++;
			end else begin
				e = pending_results.pop_front();
				if (status !== e.st || slot_index !== e.idx || found_number !== e.num ||
						found_length !== e.len || raw_offset !== e.off) begin
					$display("%0t: mismatch exp st=%0d idx=%0d num=%0d len=%0h off=%0h",
						$time, e.st, e.idx, e.num, e.len, e.off);
					$display("%0t:          act st=%0d idx=%0d num=%0d len=%0h off=%0h",
						$time, status, slot_index, found_number, found_length, raw_offset);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles > STALL_LIMIT && !done) begin
			$display("Watchdog timeout at %0t", $time);
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic test_directed();
		logic [255:0] full_name;
		full_name = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom};
		full_name[7:0] = 8'hFF;
		send_request(sfdt_pkg::FN_OPEN_NUM, 8'd0, '0, 6'd0, '0);
		send_request(sfdt_pkg::FN_OPEN_NAME, 8'd0, '0, 6'd0, '0);
		send_request(sfdt_pkg::FN_DELETE, 8'd0, '0, 6'd0, '0);
		send_request(sfdt_pkg::FN_CREATE, 8'd0, full_name, 6'd32, 24'hFFFFFF);
		send_request(sfdt_pkg::FN_CREATE, 8'd0, full_name, 6'd63, 24'd0);
		send_request(sfdt_pkg::FN_CREATE, 8'd0, ~full_name, 6'd63, 24'd100);
		send_request(sfdt_pkg::FN_CREATE, 8'd0, 256'h0102, 6'd2, 24'd1);
		send_request(sfdt_pkg::FN_OPEN_NUM, 8'd1, '0, 6'd0, '0);
		send_request(sfdt_pkg::FN_OPEN_NUM, 8'd255, '0, 6'd0, '0);
		send_request(sfdt_pkg::FN_OPEN_NAME, 8'd0, 256'h01, 6'd1, '0);
		send_request(sfdt_pkg::FN_OPEN_NAME, 8'd0, '1, 6'd0, '0);
		send_request(sfdt_pkg::FN_OPEN_NAME, 8'd0, full_name, 6'd40, '0);
		send_request(sfdt_pkg::FN_DELETE, 8'd0, full_name, 6'd32, '0);
		send_request(sfdt_pkg::FN_CREATE, 8'd0, 256'h0103, 6'd2, 24'h800000);
		send_request(sfdt_pkg::FN_DELETE, 8'd0, 256'h01, 6'd1, '0);
		send_request(sfdt_pkg::FN_DELETE, 8'd0, '0, 6'd0, '0);
		send_request(sfdt_pkg::FN_DELETE, 8'd0, '0, 6'd0, '0);
	endtask

	task automatic test_fill_table();
		// issue NSLOT + 2 creates (names repeat in pairs) to push the table toward full
		for (int i = 0; i < NSLOT + 2; i++)
			send_request(sfdt_pkg::FN_CREATE, 8'($urandom), 256'(i + 256) | 256'h1,
				6'd2, 24'($urandom_range(4096)));
		send_request(sfdt_pkg::FN_OPEN_NUM, 8'd192, '0, 6'd0, '0);
		for (int i = 0; i < 20; i++)
			send_request(sfdt_pkg::FN_DELETE, 8'd0,
				256'($urandom_range(256, 447)) | 256'h1, 6'd2, '0);
	endtask

	task automatic test_random(int n);
		sfdt_pkg::func_t f;
		int nb;
		logic [255:0] q;
		for (int i = 0; i < n; i++) begin
			idle_pct = (i > n / 3 && i < n / 2) ? 0 : 17;
			f = sfdt_pkg::func_t'($urandom_range(3));
			nb = $urandom_range(1, 4);
			q = ($urandom_range(9) == 0) ?
				{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom} : short_name(nb);
			send_request(f, 8'($urandom_range(0, 40)), q,
				($urandom_range(9) == 0) ? 6'($urandom) : 6'(nb),
				($urandom_range(4) == 0) ? 24'($urandom) : 24'($urandom_range(2048)));
		end
		idle_pct = 17;
	endtask

	initial begin
		for (int s = 0; s < NSLOT; s++)
			wipe_slot(s);
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		test_directed();
		test_random(100);
		test_fill_table();
		test_random(130);
		in_valid <= 0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (NSLOT + 10) @(posedge clk);
		done = 1;
		$display("Sent %0d requests, got %0d results: %0d creates, %0d table-full answers",
			requests, responses, n_create_ok, n_full);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
